// ===== sv/qstm_pkg.sv =====
`timescale 1ns / 1ps

package qstm_pkg;

  localparam int FIX_W  = 32;
  localparam int ROT_W  = 16;
  localparam int PROD_W = 2 * ROT_W;
  localparam int TERM_W = PROD_W + 2;
  localparam int WIDE_W = TERM_W + FIX_W;
  localparam int ROW_W  = 2;

  typedef logic signed [ROT_W-1:0]  rot_t;
  typedef logic signed [FIX_W-1:0]  fix_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [ROW_W-1:0]         row_t;

  localparam term_t ONE_Q30 = term_t'(1) <<< 30;
  localparam fix_t  ONE_Q16 = fix_t'(65536);
  localparam fix_t  FIX_MAX = fix_t'(32'h7fff_ffff);
  localparam fix_t  FIX_MIN = fix_t'(32'h8000_0000);
  localparam wide_t ROUND_HALF = wide_t'(1) <<< 29;

  localparam row_t ROW_X     = 2'd0;
  localparam row_t ROW_Y     = 2'd1;
  localparam row_t ROW_Z     = 2'd2;
  localparam row_t ROW_TRANS = 2'd3;

  // one transform with its rotation terms in Q4.30, ready for scaling
  typedef struct packed {
    term_t [8:0] term;   // row-major 3x3
    fix_t  [2:0] scale;
    fix_t  [2:0] move;
  } qstm_entry_t;

endpackage

// ===== sv/quat_scale_translate_to_matrix_core.sv =====
`timescale 1ns / 1ps

// Quaternion plus per-axis scale and translation to a 4x4 row-major transform.
// Each accepted item yields four result items, rows 0 to 3 in order, with
// last_row set on row 3. The back end emits one row per cycle while out_pop
// keeps the output register draining. The first row of an item passes through
// the input register, quaternion product register, queue, scale multiply
// register and output register, the first of them loaded at the accepting
// edge. Rotation terms are exact in Q4.30; scaled results are rounded half up
// to Q16.16 and saturated. Translation passes through unchanged, and column 3
// is 0 or 1.0.

module quat_scale_translate_to_matrix_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  qstm_pkg::rot_t in_rot_x,
  input  qstm_pkg::rot_t in_rot_y,
  input  qstm_pkg::rot_t in_rot_z,
  input  qstm_pkg::rot_t in_rot_w,
  input  qstm_pkg::fix_t in_move_x,
  input  qstm_pkg::fix_t in_move_y,
  input  qstm_pkg::fix_t in_move_z,
  input  qstm_pkg::fix_t in_scale_x,
  input  qstm_pkg::fix_t in_scale_y,
  input  qstm_pkg::fix_t in_scale_z,
  output logic           out_empty,
  input  logic           out_pop,
  output qstm_pkg::row_t out_row_index,
  output qstm_pkg::fix_t out_col0,
  output qstm_pkg::fix_t out_col1,
  output qstm_pkg::fix_t out_col2,
  output qstm_pkg::fix_t out_col3,
  output logic           out_last_row
);

  logic                  q_push, q_full, q_pop, q_empty;
  qstm_pkg::qstm_entry_t q_wdata, q_rdata;

  qstm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_rot_x   (in_rot_x),
    .in_rot_y   (in_rot_y),
    .in_rot_z   (in_rot_z),
    .in_rot_w   (in_rot_w),
    .in_move_x  (in_move_x),
    .in_move_y  (in_move_y),
    .in_move_z  (in_move_z),
    .in_scale_x (in_scale_x),
    .in_scale_y (in_scale_y),
    .in_scale_z (in_scale_z),
    .q_push     (q_push),
    .q_entry    (q_wdata),
    .q_full     (q_full)
  );

  qstm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty)
  );

  qstm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_rdata       (q_rdata),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_row_index (out_row_index),
    .out_col0      (out_col0),
    .out_col1      (out_col1),
    .out_col2      (out_col2),
    .out_col3      (out_col3),
    .out_last_row  (out_last_row)
  );

endmodule

// ===== sv/qstm_front.sv =====
`timescale 1ns / 1ps

module qstm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  qstm_pkg::rot_t       in_rot_x,
  input  qstm_pkg::rot_t       in_rot_y,
  input  qstm_pkg::rot_t       in_rot_z,
  input  qstm_pkg::rot_t       in_rot_w,
  input  qstm_pkg::fix_t       in_move_x,
  input  qstm_pkg::fix_t       in_move_y,
  input  qstm_pkg::fix_t       in_move_z,
  input  qstm_pkg::fix_t       in_scale_x,
  input  qstm_pkg::fix_t       in_scale_y,
  input  qstm_pkg::fix_t       in_scale_z,
  output logic                 q_push,
  output qstm_pkg::qstm_entry_t q_entry,
  input  logic                 q_full
);

  logic s1_valid_r, s1_valid_nxt;
  logic s2_valid_r, s2_valid_nxt;
  logic s1_ready, s2_ready;

  qstm_pkg::rot_t s1_x_r, s1_y_r, s1_z_r, s1_w_r;
  qstm_pkg::fix_t [2:0] s1_scale_r, s1_move_r;
  qstm_pkg::fix_t [2:0] s2_scale_r, s2_move_r;

  qstm_pkg::prod_t xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  qstm_pkg::prod_t xx_nxt, yy_nxt, zz_nxt, xy_nxt, xz_nxt, yz_nxt;
  qstm_pkg::prod_t wx_nxt, wy_nxt, wz_nxt;

  qstm_pkg::term_t dxx, dyy, dzz, dxy, dxz, dyz, dwx, dwy, dwz;

  function automatic qstm_pkg::term_t dbl(input qstm_pkg::prod_t p);
    return qstm_pkg::term_t'(p) <<< 1;
  endfunction

  assign s2_ready = !s2_valid_r || !q_full;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_full  = !s1_ready;
  assign q_push   = s2_valid_r && !q_full;

  assign s1_valid_nxt = s1_ready ? in_push : s1_valid_r;
  assign s2_valid_nxt = s2_ready ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_push) begin
      s1_x_r     <= in_rot_x;
      s1_y_r     <= in_rot_y;
      s1_z_r     <= in_rot_z;
      s1_w_r     <= in_rot_w;
      s1_scale_r <= {in_scale_z, in_scale_y, in_scale_x};
      s1_move_r  <= {in_move_z, in_move_y, in_move_x};
    end
  end

  assign xx_nxt = s1_x_r * s1_x_r;
  assign yy_nxt = s1_y_r * s1_y_r;
  assign zz_nxt = s1_z_r * s1_z_r;
  assign xy_nxt = s1_x_r * s1_y_r;
  assign xz_nxt = s1_x_r * s1_z_r;
  assign yz_nxt = s1_y_r * s1_z_r;
  assign wx_nxt = s1_w_r * s1_x_r;
  assign wy_nxt = s1_w_r * s1_y_r;
  assign wz_nxt = s1_w_r * s1_z_r;

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      xx_r       <= xx_nxt;
      yy_r       <= yy_nxt;
      zz_r       <= zz_nxt;
      xy_r       <= xy_nxt;
      xz_r       <= xz_nxt;
      yz_r       <= yz_nxt;
      wx_r       <= wx_nxt;
      wy_r       <= wy_nxt;
      wz_r       <= wz_nxt;
      s2_scale_r <= s1_scale_r;
      s2_move_r  <= s1_move_r;
    end
  end

  assign dxx = dbl(xx_r);
  assign dyy = dbl(yy_r);
  assign dzz = dbl(zz_r);
  assign dxy = dbl(xy_r);
  assign dxz = dbl(xz_r);
  assign dyz = dbl(yz_r);
  assign dwx = dbl(wx_r);
  assign dwy = dbl(wy_r);
  assign dwz = dbl(wz_r);

  always_comb begin
    q_entry.term[0] = qstm_pkg::ONE_Q30 - (dyy + dzz);
    q_entry.term[1] = dxy + dwz;
    q_entry.term[2] = dxz - dwy;
    q_entry.term[3] = dxy - dwz;
    q_entry.term[4] = qstm_pkg::ONE_Q30 - (dxx + dzz);
    q_entry.term[5] = dyz + dwx;
    q_entry.term[6] = dxz + dwy;
    q_entry.term[7] = dyz - dwx;
    q_entry.term[8] = qstm_pkg::ONE_Q30 - (dxx + dyy);
    q_entry.scale   = s2_scale_r;
    q_entry.move    = s2_move_r;
  end

endmodule

// ===== sv/qstm_queue.sv =====
`timescale 1ns / 1ps

module qstm_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_push,
  input  qstm_pkg::qstm_entry_t q_wdata,
  output logic                  q_full,
  input  logic                  q_pop,
  output qstm_pkg::qstm_entry_t q_rdata,
  output logic                  q_empty
);

  qstm_pkg::qstm_entry_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign q_full  = (count_r == 2'd2);
  assign q_empty = (count_r == 2'd0);
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_rdata = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = wr_ptr_r ^ do_push;
  assign rd_ptr_nxt = rd_ptr_r ^ do_pop;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

// ===== sv/qstm_back.sv =====
`timescale 1ns / 1ps

module qstm_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  qstm_pkg::qstm_entry_t q_rdata,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output qstm_pkg::row_t        out_row_index,
  output qstm_pkg::fix_t        out_col0,
  output qstm_pkg::fix_t        out_col1,
  output qstm_pkg::fix_t        out_col2,
  output qstm_pkg::fix_t        out_col3,
  output logic                  out_last_row
);

  qstm_pkg::row_t row_r, row_nxt;
  logic issue;
  logic b1_valid_r, b1_valid_nxt;
  logic b1_ready;
  logic out_valid_r, out_valid_nxt;
  logic out_ready;

  qstm_pkg::term_t sel_term [3];
  qstm_pkg::fix_t  sel_scale;
  logic signed [49:0] ph_nxt [3];
  logic signed [48:0] pl_nxt [3];

  qstm_pkg::row_t     b1_row_r;
  logic signed [49:0] b1_ph_r [3];
  logic signed [48:0] b1_pl_r [3];
  qstm_pkg::fix_t     b1_move_r [3];

  qstm_pkg::row_t out_row_r;
  qstm_pkg::fix_t out_col_r [4];
  qstm_pkg::fix_t col_nxt [4];

  // Q20.46 product back to Q16.16: round half up, then clamp
  function automatic qstm_pkg::fix_t round_sat(input qstm_pkg::wide_t p);
    qstm_pkg::wide_t    pr;
    logic signed [35:0] q;
    pr = p + qstm_pkg::ROUND_HALF;
    q  = pr[65:30];
    if (q[35:31] == 5'b00000 || q[35:31] == 5'b11111) begin
      return q[31:0];
    end else if (q[35]) begin
      return qstm_pkg::FIX_MIN;
    end else begin
      return qstm_pkg::FIX_MAX;
    end
  endfunction

  assign out_ready = !out_valid_r || out_pop;
  assign b1_ready  = !b1_valid_r || out_ready;
  assign issue     = !q_empty && b1_ready;
  assign q_pop     = issue && (row_r == qstm_pkg::ROW_TRANS);

  assign row_nxt       = issue ? row_r + 2'd1 : row_r;
  assign b1_valid_nxt  = b1_ready ? issue : b1_valid_r;
  assign out_valid_nxt = out_ready ? b1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= qstm_pkg::ROW_X;
      b1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      b1_valid_r  <= b1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    unique case (row_r)
      qstm_pkg::ROW_X: begin
        sel_term[0] = q_rdata.term[0];
        sel_term[1] = q_rdata.term[1];
        sel_term[2] = q_rdata.term[2];
        sel_scale   = q_rdata.scale[0];
      end
      qstm_pkg::ROW_Y: begin
        sel_term[0] = q_rdata.term[3];
        sel_term[1] = q_rdata.term[4];
        sel_term[2] = q_rdata.term[5];
        sel_scale   = q_rdata.scale[1];
      end
      default: begin
        sel_term[0] = q_rdata.term[6];
        sel_term[1] = q_rdata.term[7];
        sel_term[2] = q_rdata.term[8];
        sel_scale   = q_rdata.scale[2];
      end
    endcase
  end

  // split each term into a signed upper and an unsigned lower part
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ph_nxt[c] = $signed(sel_term[c][33:16]) * sel_scale;
      pl_nxt[c] = $signed({1'b0, sel_term[c][15:0]}) * sel_scale;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b1_row_r <= row_r;
      for (int c = 0; c < 3; c++) begin
        b1_ph_r[c]   <= ph_nxt[c];
        b1_pl_r[c]   <= pl_nxt[c];
        b1_move_r[c] <= q_rdata.move[c];
      end
    end
  end

  always_comb begin
    if (b1_row_r == qstm_pkg::ROW_TRANS) begin
      for (int c = 0; c < 3; c++) begin
        col_nxt[c] = b1_move_r[c];
      end
      col_nxt[3] = qstm_pkg::ONE_Q16;
    end else begin
      for (int c = 0; c < 3; c++) begin
        col_nxt[c] = round_sat((qstm_pkg::wide_t'(b1_ph_r[c]) <<< 16)
                               + qstm_pkg::wide_t'(b1_pl_r[c]));
      end
      col_nxt[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && b1_valid_r) begin
      out_row_r <= b1_row_r;
      out_col_r <= col_nxt;
    end
  end

  assign out_empty     = !out_valid_r;
  assign out_row_index = out_row_r;
  assign out_col0      = out_col_r[0];
  assign out_col1      = out_col_r[1];
  assign out_col2      = out_col_r[2];
  assign out_col3      = out_col_r[3];
  assign out_last_row  = (out_row_r == qstm_pkg::ROW_TRANS);

endmodule
